// ===== rtl/isq_pkg.sv =====
// isq_pkg: shared types and constants for the indexed sequence store.
// Used by isq_cell and indexed_sequence_store; depends on nothing.
`default_nettype none

package isq_pkg;

    // List geometry
    localparam int DEPTH   = 16;
    localparam int IDX_W   = $clog2(DEPTH);
    localparam int POS_W   = 5;
    localparam int VAL_W   = 32;
    localparam int FUNC_W  = 2;
    localparam int STAT_W  = 2;

    // Beat widths (padded to whole bytes)
    localparam int S_DATA_W = 40;
    localparam int M_DATA_W = 40;

    // Value returned by a read past the end of the list
    localparam logic signed [VAL_W-1:0] MISS_VALUE = 32'sd7;

    // Operation codes
    typedef enum logic [FUNC_W-1:0] {
        OP_READ   = 2'd0,
        OP_INSERT = 2'd1,
        OP_REMOVE = 2'd2,
        OP_CLEAR  = 2'd3
    } isq_op_t;

    // Status codes
    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2,
        ST_EMPTY = 2'd3
    } isq_status_t;

    // Command broadcast to every cell of the chain
    typedef struct packed {
        logic                    ins;
        logic                    rem;
        logic [POS_W-1:0]        pos;
        logic signed [VAL_W-1:0] val;
    } isq_cmd_t;

endpackage

`default_nettype wire

// ===== rtl/isq_cell.sv =====
// isq_cell: one entry of the list; loads from its lower or upper neighbor
// or from the insert value. Depends on isq_pkg.
`default_nettype none

module isq_cell #(
    parameter int CELL_IDX = 0
) (
    input  wire                                   aclk,
    input  isq_pkg::isq_cmd_t                     cmd,
    input  wire  logic signed [isq_pkg::VAL_W-1:0] left_value,
    input  wire  logic signed [isq_pkg::VAL_W-1:0] right_value,
    output logic signed [isq_pkg::VAL_W-1:0]      value
);

    localparam logic [isq_pkg::POS_W-1:0] MY_POS = isq_pkg::POS_W'(CELL_IDX);

    logic signed [isq_pkg::VAL_W-1:0] value_reg;
    logic signed [isq_pkg::VAL_W-1:0] value_next;

    // Insert: cells above the slot shift up, the slot takes the new value.
    // Remove: the slot and cells above it pull down from the upper neighbor.
    always_comb begin
        value_next = value_reg;
        if (cmd.ins) begin
            if (MY_POS > cmd.pos) begin
                value_next = left_value;
            end else if (MY_POS == cmd.pos) begin
                value_next = cmd.val;
            end
        end else if (cmd.rem) begin
            if (MY_POS >= cmd.pos) begin
                value_next = right_value;
            end
        end
    end

    // Payload only, no reset
    always_ff @(posedge aclk) begin
        value_reg <= value_next;
    end

    assign value = value_reg;

endmodule

`default_nettype wire

// ===== rtl/indexed_sequence_store.sv =====
// indexed_sequence_store: bounded ordered list of signed 32-bit entries
// built as a chain of shifting cells. Depends on isq_pkg and isq_cell.
//
// Usage:
//   Input beats (s_*) carry one operation each: func in s_tuser selects
//   read, insert, remove or clear; s_tdata carries position and value_in.
//   Every input beat yields exactly one result beat (m_*) with the value
//   read (7 for a read past the end, 0 for a non-read operation), the count
//   after the operation, and a status code in m_tuser.
//   Result: registered; m_tvalid rises in the cycle after the beat is accepted.
//   Throughput: one operation per cycle while m_tready is high; all cells shift
//   in parallel in the cycle the beat is accepted; the read is a mux over the cells.
//   Stalls: the single result register holds its beat while m_tready is
//   low; out of reset, s_tready is high whenever that register is empty or
//   being drained in the same cycle.
//   Reset: aresetn (synchronous, active low) empties the list and the
//   result register and holds s_tready low. Entry contents are not
//   cleared; only positions below the count are ever read.
`default_nettype none

module indexed_sequence_store (
    input  wire                                aclk,
    input  wire                                aresetn,
    // Input channel
    input  wire                                s_tvalid,
    output logic                               s_tready,
    input  wire  [isq_pkg::S_DATA_W-1:0]       s_tdata,  // [4:0] position, [36:5] value_in
    input  wire  [isq_pkg::FUNC_W-1:0]         s_tuser,  // [1:0] func
    // Result channel
    output logic                               m_tvalid,
    input  wire                                m_tready,
    output logic [isq_pkg::M_DATA_W-1:0]       m_tdata,  // [31:0] value_out, [36:32] count
    output logic [isq_pkg::STAT_W-1:0]         m_tuser   // [1:0] status
);

    localparam int DEPTH = isq_pkg::DEPTH;
    localparam logic [isq_pkg::POS_W-1:0] FULL_COUNT = isq_pkg::POS_W'(DEPTH);

    // Unpacked input beat
    logic [isq_pkg::POS_W-1:0]        in_pos;
    logic signed [isq_pkg::VAL_W-1:0] in_val;
    isq_pkg::isq_op_t                 in_op;
    logic                             s_accept;

    assign in_pos   = s_tdata[isq_pkg::POS_W-1:0];
    assign in_val   = s_tdata[isq_pkg::POS_W +: isq_pkg::VAL_W];
    assign in_op    = isq_pkg::isq_op_t'(s_tuser);
    assign s_accept = s_tvalid && s_tready;

    // Control state
    logic [isq_pkg::POS_W-1:0]  count_reg, count_next;
    logic                       m_valid_reg, m_valid_next;
    // Result payload
    logic signed [isq_pkg::VAL_W-1:0] rd_reg, rd_next;
    logic [isq_pkg::POS_W-1:0]        cnt_out_reg;
    isq_pkg::isq_status_t             st_reg, st_next;

    // Cell chain
    isq_pkg::isq_cmd_t                cmd;
    logic signed [isq_pkg::VAL_W-1:0] entry_w [DEPTH];
    logic signed [isq_pkg::VAL_W-1:0] read_value;

    assign s_tready   = aresetn && (!m_valid_reg || m_tready);
    assign read_value = entry_w[in_pos[isq_pkg::IDX_W-1:0]];

    // Decode the operation, check bounds, build the cell command
    always_comb begin
        cmd.ins    = 1'b0;
        cmd.rem    = 1'b0;
        cmd.pos    = in_pos;
        cmd.val    = in_val;
        rd_next    = '0;
        st_next    = isq_pkg::ST_OK;
        count_next = count_reg;
        case (in_op)
            isq_pkg::OP_READ: begin
                if (in_pos < count_reg) begin
                    rd_next = read_value;
                end else begin
                    rd_next = isq_pkg::MISS_VALUE;
                    st_next = isq_pkg::ST_RANGE;
                end
            end
            isq_pkg::OP_INSERT: begin
                if (count_reg >= FULL_COUNT) begin
                    st_next = isq_pkg::ST_FULL;
                end else if (in_pos > count_reg) begin
                    st_next = isq_pkg::ST_RANGE;
                end else begin
                    cmd.ins    = s_accept;
                    count_next = count_reg + 1'b1;
                end
            end
            isq_pkg::OP_REMOVE: begin
                if (count_reg == '0) begin
                    st_next = isq_pkg::ST_EMPTY;
                end else if (in_pos >= count_reg) begin
                    st_next = isq_pkg::ST_RANGE;
                end else begin
                    cmd.rem    = s_accept;
                    count_next = count_reg - 1'b1;
                end
            end
            isq_pkg::OP_CLEAR: begin
                count_next = '0;
            end
            default: begin
                count_next = count_reg;
            end
        endcase
    end

    // Result register handshake
    always_comb begin
        m_valid_next = m_valid_reg;
        if (s_accept) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
            if (s_accept) begin
                count_reg <= count_next;
            end
        end
    end

    // Result payload registers
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            rd_reg      <= rd_next;
            cnt_out_reg <= count_next;
            st_reg      <= st_next;
        end
    end

    // Chain of cells: each sees its lower and upper neighbor (an end cell sees itself)
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic signed [isq_pkg::VAL_W-1:0] left_w;
        logic signed [isq_pkg::VAL_W-1:0] right_w;

        if (i == 0) begin : g_first
            assign left_w = entry_w[i];
        end else begin : g_mid_lo
            assign left_w = entry_w[i-1];
        end

        if (i == DEPTH - 1) begin : g_last
            assign right_w = entry_w[i];
        end else begin : g_mid_hi
            assign right_w = entry_w[i+1];
        end

        isq_cell #(
            .CELL_IDX (i)
        ) u_cell (
            .aclk        (aclk),
            .cmd         (cmd),
            .left_value  (left_w),
            .right_value (right_w),
            .value       (entry_w[i])
        );
    end

    // Output beat
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(isq_pkg::M_DATA_W - isq_pkg::VAL_W - isq_pkg::POS_W){1'b0}},
                       cnt_out_reg, rd_reg};
    assign m_tuser  = st_reg;

    // Assertions
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= FULL_COUNT)
        else $error("list count exceeds depth");

    a_insert_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && in_op == isq_pkg::OP_INSERT && count_reg < FULL_COUNT
         && in_pos <= count_reg) |=> count_reg == $past(count_reg) + 1'b1)
        else $error("accepted insert did not grow the list");

    a_clear_empties: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && in_op == isq_pkg::OP_CLEAR) |=> count_reg == '0 && m_valid_reg)
        else $error("clear did not empty the list");

    a_result_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept) |=> cnt_out_reg == count_reg)
        else $error("reported count differs from list count");

endmodule

`default_nettype wire
